// ===== src/iks_pkg.sv =====
// Shared types for the integer key sorter
package iks_pkg;

	typedef logic signed [31:0] key_t;

	typedef struct packed {
		logic ins;   // insert the broadcast key this cycle
		logic shl;   // shift the chain one place towards cell 0
	} ctrl_t;

endpackage

// ===== src/iks_cell.sv =====
// One cell of the insertion chain: holds one key and its valid bit
module iks_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  iks_pkg::ctrl_t ctrl,
	input  iks_pkg::key_t  new_key,
	input  iks_pkg::key_t  left_key,
	input  logic          left_valid,
	input  logic          left_gt,
	input  iks_pkg::key_t  right_key,
	input  logic          right_valid,
	output iks_pkg::key_t  cell_key,
	output logic          cell_valid,
	output logic          cell_gt
);
	import iks_pkg::*;

	key_t key_q;
	logic valid_q;

	// empty cells count as greater than any key; equal keys stay ahead
	assign cell_gt    = !valid_q || (key_q > new_key);
	assign cell_key   = key_q;
	assign cell_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shl) begin
			valid_q <= right_valid;
		end else if (ctrl.ins && cell_gt) begin
			valid_q <= left_gt ? left_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shl) begin
			key_q <= right_key;
		end else if (ctrl.ins && cell_gt) begin
			key_q <= left_gt ? left_key : new_key;
		end
	end

endmodule

// ===== src/integer_key_sorter_core.sv =====
// Integer key sorter: systolic insertion chain with ordered drain
// Loading: one key per cycle, start accepted whenever busy is low.
// Drain: after the final key, results follow from the next cycle, one per cycle,
// one result per held key, with busy high for the whole drain.
// Per list: keys load first, then drain; no new key is taken until the drain ends.
// Reset clears all valid bits, the drain flag and the overflow flag; results cannot stall.
module integer_key_sorter_core #(
	parameter int MAX_KEYS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  iks_pkg::key_t  key,
	input  logic          is_last,
	output logic          strobe,
	output iks_pkg::key_t  sorted_key,
	output logic          last_out,
	output logic          overflow
);
	import iks_pkg::*;

	key_t  c_key   [MAX_KEYS];
	logic  c_valid [MAX_KEYS];
	logic  c_gt    [MAX_KEYS];
	ctrl_t ctrl;
	logic  accept;
	logic  full;
	logic  draining_q;
	logic  dropped_q;

	assign accept   = start && !busy;
	assign full     = c_valid[MAX_KEYS-1];
	assign ctrl.ins = accept && !full;
	assign ctrl.shl = draining_q;

	for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
		key_t lk;
		logic lv;
		logic lg;
		key_t rk;
		logic rv;

		if (i == 0) begin : g_first
			assign lk = key;
			assign lv = 1'b1;
			assign lg = 1'b0;
		end else begin : g_mid
			assign lk = c_key[i-1];
			assign lv = c_valid[i-1];
			assign lg = c_gt[i-1];
		end

		if (i == MAX_KEYS - 1) begin : g_end
			assign rk = key;
			assign rv = 1'b0;
		end else begin : g_body
			assign rk = c_key[i+1];
			assign rv = c_valid[i+1];
		end

		iks_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_key    (key),
			.left_key   (lk),
			.left_valid (lv),
			.left_gt    (lg),
			.right_key  (rk),
			.right_valid(rv),
			.cell_key   (c_key[i]),
			.cell_valid (c_valid[i]),
			.cell_gt    (c_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			dropped_q  <= 1'b0;
		end else if (draining_q) begin
			draining_q <= c_valid[1];
			if (!c_valid[1]) begin
				dropped_q <= 1'b0;
			end
		end else if (accept) begin
			draining_q <= is_last;
			if (full) begin
				dropped_q <= 1'b1;
			end
		end
	end

	assign busy       = draining_q;
	assign strobe     = draining_q;
	assign sorted_key = c_key[0];
	assign last_out   = !c_valid[1];
	assign overflow   = dropped_q;

	a_strobe_has_key: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> c_valid[0])
		else $error("result strobe with empty head cell");

	a_last_ends_drain: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_out |=> !busy && !overflow)
		else $error("drain did not end after last result");

	a_drain_continues: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_out |=> strobe && overflow == $past(overflow))
		else $error("drain broke off before last result");

	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_out |=> sorted_key >= $past(sorted_key))
		else $error("results out of order");

endmodule

// ===== dv/integer_key_sorter_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the integer key sorter core: directed, capacity and random lists
module integer_key_sorter_core_test;
	import iks_pkg::*;

	localparam int CAPACITY = 64;
	localparam int STALL_LIMIT = 1000;

	typedef struct {
		key_t k;
		logic last;
		logic ovf;
	} sorted_rec_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	key_t key;
	logic is_last;
	logic strobe;
	key_t sorted_key;
	logic last_out;
	logic overflow;

	key_t held_keys[$];
	logic keys_dropped;
	sorted_rec_t pending_sorted[$];

	int idle_pct;
	int errors;
	int keys_sent;
	int lists_sent;
	int lists_overflowed;
	int results_checked;
	int quiet_cycles;

	integer_key_sorter_core #(
		.MAX_KEYS(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.key(key),
		.is_last(is_last),
		.strobe(strobe),
		.sorted_key(sorted_key),
		.last_out(last_out),
		.overflow(overflow)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// stable insertion: equal keys keep arrival order
	function automatic void absorb_key(input key_t k, input logic l);
		int pos;
		sorted_rec_t rec;
		if (held_keys.size() < CAPACITY) begin
			pos = held_keys.size();
			while (pos > 0 && held_keys[pos - 1] > k)
				pos--;
			held_keys.insert(pos, k);
		end else begin
			keys_dropped = 1'b1;
		end
		if (l) begin
			foreach (held_keys[i]) begin
				rec.k = held_keys[i];
				rec.last = (i == held_keys.size() - 1);
				rec.ovf = keys_dropped;
				pending_sorted.push_back(rec);
			end
			if (keys_dropped)
				lists_overflowed++;
			held_keys.delete();
			keys_dropped = 1'b0;
		end
	endfunction

	always @(posedge clk) begin
		sorted_rec_t exp_rec;
		logic progress;
		if (arst_n) begin
			progress = start && !busy;
			if (strobe) begin
				if (pending_sorted.size() == 0) begin
					$error("unexpected result: sorted_key %0d", sorted_key);
					errors++;
				end else begin
					exp_rec = pending_sorted.pop_front();
					results_checked++;
					progress = 1'b1;
					if (sorted_key !== exp_rec.k) begin
						$error("sorted_key: expected %0d, actual %0d", exp_rec.k, sorted_key);
						errors++;
					end
					if (last_out !== exp_rec.last) begin
						$error("last_out: expected %0b, actual %0b", exp_rec.last, last_out);
						errors++;
					end
					if (overflow !== exp_rec.ovf) begin
						$error("overflow: expected %0b, actual %0b", exp_rec.ovf, overflow);
						errors++;
					end
				end
			end
			if (start && !busy)
				absorb_key(key, is_last);
			if (progress)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	function automatic key_t rand_key();
		case ($urandom_range(3))
			0: return $signed($urandom_range(16)) - 8;
			1: return $urandom_range(1) ? 32'sh7FFF_FFFF - $urandom_range(3)
				: 32'sh8000_0000 + $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_key(input key_t k, input logic l);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			key <= $urandom;
			is_last <= $urandom_range(1);
		end
		@(negedge clk);
		start <= 1'b1;
		key <= k;
		is_last <= l;
		do @(posedge clk); while (busy);
		keys_sent++;
	endtask

	task automatic send_list(input key_t ks[$]);
		foreach (ks[i])
			send_key(ks[i], i == ks.size() - 1);
		lists_sent++;
	endtask

	task automatic test_directed();
		send_list('{32'sh8000_0000});
		send_list('{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 32'sh7FFF_FFFF,
			32'sh8000_0000, -1});
		send_list('{5, 5, 5});
		send_list('{-3, -2, -1, 0, 1, 2});
		send_list('{100, 50, 0, -50});
	endtask

	// a list that fills the store, then has its tail, final key included, dropped
	task automatic test_capacity();
		key_t ks[$];
		repeat (CAPACITY + 2)
			ks.push_back(rand_key());
		send_list(ks);
	endtask

	task automatic test_random(input int pct, input int n_keys);
		key_t ks[$];
		int len;
		int target;
		idle_pct = pct;
		target = keys_sent + n_keys;
		while (keys_sent < target) begin
			len = ($urandom_range(15) == 0) ? $urandom_range(CAPACITY - 4, CAPACITY + 6)
				: $urandom_range(1, 10);
			if (len > target - keys_sent)
				len = target - keys_sent;
			ks.delete();
			repeat (len)
				ks.push_back(rand_key());
			send_list(ks);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		key = '0;
		is_last = 1'b0;
		keys_dropped = 1'b0;
		idle_pct = 24;
		errors = 0;
		keys_sent = 0;
		lists_sent = 0;
		lists_overflowed = 0;
		results_checked = 0;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_capacity();
		test_random(24, 24);
		test_random(49, 24);
		test_random(0, 24);

		@(negedge clk);
		start <= 1'b0;
		wait (pending_sorted.size() == 0);
		repeat (8) @(posedge clk);
		errors += pending_sorted.size();

		$display("Sorted %0d keys in %0d lists (%0d with dropped keys), %0d results checked",
			keys_sent, lists_sent, lists_overflowed, results_checked);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
